@@ hdl/rca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

  // Fixed field widths of the stream words and registers.
  localparam int unsigned ChanW     = 8;
  localparam int unsigned SumW      = 32;
  localparam int unsigned AreaOutW  = 25;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 56;

  // One quotient bit per divider step.
  localparam int unsigned DivSteps  = SumW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BOX_LEFT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BOX_TOP      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BOX_COLS     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BOX_ROWS     = 3'd5;

  typedef struct packed {
    logic [12:0]        frame_width;
    logic [12:0]        frame_height;
    logic signed [12:0] box_left;
    logic signed [12:0] box_top;
    logic signed [13:0] box_cols;
    logic signed [13:0] box_rows;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] chan2;
    logic [ChanW-1:0] chan1;
    logic [ChanW-1:0] chan0;
  } pix_t;

  typedef struct packed {
    logic [AreaOutW-1:0] box_area;
    logic                empty_box;
    logic [ChanW-1:0]    mean2;
    logic [ChanW-1:0]    mean1;
    logic [ChanW-1:0]    mean0;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic pix_take;   // pixel word accepted this cycle
    logic div_step;   // advance the dividers by one bit
    logic out_load;   // capture quotients into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_end;  // the pixel at the input is the last one of the frame
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/roi_color_average_top.sv @@
// Mean color over a region of interest of an RGB-style pixel stream.
//
// Pixels enter on the slave stream, one three-byte word per cycle, in raster
// order. The frame size and the requested box come from the configuration
// write port. The box is clamped to the frame, and the three channels are
// summed over the pixels that fall inside it. After the last pixel of each
// frame one result word leaves on the master stream: the truncated mean of
// each channel, the clamped box area, and in tuser a flag for an empty box
// (then the means and the area are zero).
//
// Throughput: one pixel per cycle within a frame. After the last pixel the
// input stalls while three shared-step restoring dividers produce the
// quotients, one bit per cycle; the quotients are then loaded into the
// output register, which raises the result valid. Reset clears the
// position and the sums and loads the register defaults (640 by 480, empty
// box). The output register holds a result while the receiver stalls; the
// next frame streams in meanwhile and only its own result waits for the
// register to free up.
`timescale 1ns / 1ps
`default_nettype none

module roi_color_average_top
  import rca_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // chan0, chan1, chan2
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,   // mean0, mean1, mean2, box_area, zero pad
  output logic                      m_axis_tuser,   // empty_box
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  pix_t pix;
  cmd_t cmd;
  sts_t sts;
  res_t res;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= 13'd640;
      cfg_q.frame_height <= 13'd480;
      cfg_q.box_left     <= '0;
      cfg_q.box_top      <= '0;
      cfg_q.box_cols     <= '0;
      cfg_q.box_rows     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[12:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[12:0];
        REG_BOX_LEFT:     cfg_q.box_left     <= cfg_data_i[12:0];
        REG_BOX_TOP:      cfg_q.box_top      <= cfg_data_i[12:0];
        REG_BOX_COLS:     cfg_q.box_cols     <= cfg_data_i;
        REG_BOX_ROWS:     cfg_q.box_rows     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign pix = pix_t'(s_axis_tdata);

  rca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rca_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  // Result word: the three means in the low bytes, then the 25-bit area.
  assign m_axis_tdata = {7'd0, res.box_area, res.mean2, res.mean1, res.mean0};
  assign m_axis_tuser = res.empty_box;

endmodule

`default_nettype wire

@@ hdl/rca_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rca_ctrl
  import rca_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  localparam logic [DivCntW-1:0] CntLast = DivCntW'(DivSteps - 1);

  logic [1:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               ovalid_q, ovalid_d;
  logic               out_free;

  assign out_free   = !ovalid_q || m_tready_i;
  assign s_tready_o = (state_q == S_RUN);
  assign m_tvalid_o = ovalid_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    ovalid_d       = ovalid_q && !m_tready_i;
    cmd_o.pix_take = (state_q == S_RUN) && s_tvalid_i;
    cmd_o.div_step = 1'b0;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_RUN: begin
        if (s_tvalid_i && sts_i.frame_end) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RUN;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // The last pixel of a frame always starts a division.
  a_frame_end_divides : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pix_take && sts_i.frame_end) |=> (state_q == S_DIV && cnt_q == '0))
    else $error("frame end did not start the divider");

  // A waiting result is never overwritten by the next frame's result.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_tready_i) |-> !cmd_o.out_load)
    else $error("result overwritten while stalled");

  // The divider runs its full number of steps before the result is loaded.
  a_div_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && $past(state_q) == S_DIV) |-> $past(cnt_q) == CntLast)
    else $error("divider left early");

endmodule

`default_nettype wire

@@ hdl/rca_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rca_dpath
  import rca_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire pix_t pix_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output res_t      res_o
);

  localparam int unsigned DW  = $clog2(MAX_DIM + 1);
  localparam int unsigned PW  = $clog2(MAX_DIM);
  localparam int unsigned SW  = ((DW > 14) ? DW : 14) + 2;
  localparam int unsigned AW  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned AXW = (AW > AreaOutW) ? AW : AreaOutW;
  localparam logic signed [SW-1:0] MaxS = SW'(MAX_DIM);

  // Clamp one axis: returns {origin, length}.
  function automatic logic [2*SW-1:0] clamp_axis(input logic signed [SW-1:0] org_in,
                                                  input logic signed [SW-1:0] len_in,
                                                  input logic signed [SW-1:0] ext);
    logic signed [SW-1:0] o;
    logic signed [SW-1:0] l;
    o = (org_in < 0) ? '0 : org_in;
    l = (len_in < 0) ? '0 : len_in;
    if (o + l > ext) l = ext - o;
    if (l < 0) l = '0;
    return {o, l};
  endfunction

  logic signed [SW-1:0] fw_s, fh_s, w_s, h_s;
  logic signed [SW-1:0] bx, bw, by, bh, c_s, r_s;
  logic [DW-1:0]        bw_u, bh_u;
  logic [AW-1:0]        area_c;
  logic                 in_box, last_col, last_row;
  logic [SumW-1:0]      add0, add1, add2;
  logic [SumW-1:0]      sum0_nx, sum1_nx, sum2_nx;

  logic [PW-1:0]   col_q, row_q;
  logic [SumW-1:0] sum0_q, sum1_q, sum2_q;
  logic [AW-1:0]   area_q;
  logic [SumW-1:0] dvd_q [3];
  logic [AW-1:0]   rem_q [3];
  logic [AW:0]     trial [3];
  logic            take  [3];
  logic [AXW-1:0]  area_x;
  res_t            res_q;

  always_comb begin
    fw_s = $signed({{(SW-13){1'b0}}, cfg_i.frame_width});
    fh_s = $signed({{(SW-13){1'b0}}, cfg_i.frame_height});
    w_s  = (fw_s == 0) ? SW'(1) : ((fw_s > MaxS) ? MaxS : fw_s);
    h_s  = (fh_s == 0) ? SW'(1) : ((fh_s > MaxS) ? MaxS : fh_s);
    {bx, bw} = clamp_axis($signed({{(SW-13){cfg_i.box_left[12]}}, cfg_i.box_left}),
                          $signed({{(SW-14){cfg_i.box_cols[13]}}, cfg_i.box_cols}), w_s);
    {by, bh} = clamp_axis($signed({{(SW-13){cfg_i.box_top[12]}}, cfg_i.box_top}),
                          $signed({{(SW-14){cfg_i.box_rows[13]}}, cfg_i.box_rows}), h_s);
    bw_u   = bw[DW-1:0];
    bh_u   = bh[DW-1:0];
    area_c = AW'(bw_u) * AW'(bh_u);
    c_s    = $signed({{(SW-PW){1'b0}}, col_q});
    r_s    = $signed({{(SW-PW){1'b0}}, row_q});
    in_box = (c_s >= bx) && (c_s < bx + bw) && (r_s >= by) && (r_s < by + bh);
    last_col = (c_s >= w_s - 1);
    last_row = (r_s >= h_s - 1);
    add0   = in_box ? SumW'(pix_i.chan0) : '0;
    add1   = in_box ? SumW'(pix_i.chan1) : '0;
    add2   = in_box ? SumW'(pix_i.chan2) : '0;
    sum0_nx = sum0_q + add0;
    sum1_nx = sum1_q + add1;
    sum2_nx = sum2_q + add2;
  end

  assign sts_o.frame_end = last_col && last_row;

  // Position counters and channel sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      sum0_q <= '0;
      sum1_q <= '0;
      sum2_q <= '0;
    end else if (cmd_i.pix_take) begin
      if (!last_col) begin
        col_q <= col_q + 1'b1;
      end else begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + 1'b1;
      end
      if (sts_o.frame_end) begin
        sum0_q <= '0;
        sum1_q <= '0;
        sum2_q <= '0;
      end else begin
        sum0_q <= sum0_nx;
        sum1_q <= sum1_nx;
        sum2_q <= sum2_nx;
      end
    end
  end

  // Three restoring dividers, one quotient bit per step; the dividend
  // register shifts the quotient in from the bottom.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem_q[k], dvd_q[k][SumW-1]};
      take[k]  = (trial[k] >= {1'b0, area_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take && sts_o.frame_end) begin
      dvd_q[0] <= sum0_nx;
      dvd_q[1] <= sum1_nx;
      dvd_q[2] <= sum2_nx;
      area_q   <= area_c;
      for (int k = 0; k < 3; k++) rem_q[k] <= '0;
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        dvd_q[k] <= {dvd_q[k][SumW-2:0], take[k]};
        rem_q[k] <= take[k] ? AW'(trial[k] - {1'b0, area_q}) : trial[k][AW-1:0];
      end
    end
  end

  assign area_x = AXW'(area_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.empty_box <= (area_q == '0);
      res_q.box_area  <= area_x[AreaOutW-1:0];
      res_q.mean0     <= (area_q == '0) ? '0 : dvd_q[0][ChanW-1:0];
      res_q.mean1     <= (area_q == '0) ? '0 : dvd_q[1][ChanW-1:0];
      res_q.mean2     <= (area_q == '0) ? '0 : dvd_q[2][ChanW-1:0];
    end
  end

  assign res_o = res_q;

  // An empty box always reports zero means.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && area_q == '0) |=>
      (res_q.empty_box && res_q.mean0 == '0 && res_q.mean1 == '0 && res_q.mean2 == '0))
    else $error("empty box gave a nonzero mean");

endmodule

`default_nettype wire
